[rtl/fir_pkg.sv]
`default_nettype none

package fir_pkg;

    localparam int DATA_W     = 16;
    localparam int IDX_W      = 5;
    localparam int FRAC_SHIFT = 14;

    typedef logic signed [DATA_W-1:0] sample_t;
    typedef logic signed [DATA_W-1:0] coef_t;
    typedef logic        [1:0]        op_t;
    typedef logic        [IDX_W-1:0]  tap_idx_t;

    localparam op_t OP_SAMPLE = 2'd0;
    localparam op_t OP_WRITE  = 2'd1;
    localparam op_t OP_CLEAR  = 2'd2;

    // Q2.14 unity, the reset value of tap zero
    localparam coef_t   COEF_ONE   = 16'sd16384;
    localparam sample_t SAMPLE_MAX = 16'sh7fff;
    localparam sample_t SAMPLE_MIN = 16'sh8000;
    localparam int      ROUND_HALF = 8192;

    typedef struct packed {
        logic     shift;
        logic     rotate;
        logic     clear;
        logic     wr_en;
        tap_idx_t wr_idx;
        coef_t    wr_value;
    } cell_ctrl_t;

    typedef struct packed {
        logic start;
        logic en;
    } mac_ctrl_t;

endpackage

`default_nettype wire

[rtl/fir_in_if.sv]
`default_nettype none

interface fir_in_if;
    logic               valid;
    logic               ready;
    fir_pkg::op_t       op;
    fir_pkg::sample_t   sample_in;
    fir_pkg::tap_idx_t  tap_index;
    fir_pkg::coef_t     tap_value;

    modport source (output valid, output op, output sample_in, output tap_index,
                    output tap_value, input ready);
    modport sink   (input valid, input op, input sample_in, input tap_index,
                    input tap_value, output ready);
endinterface

`default_nettype wire

[rtl/fir_out_if.sv]
`default_nettype none

interface fir_out_if;
    logic             valid;
    logic             ready;
    fir_pkg::sample_t sample_out;
    logic             clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

[rtl/fir_cell.sv]
`default_nettype none

module fir_cell #(
    parameter int INDEX = 0
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  fir_pkg::cell_ctrl_t  ctrl,
    input  fir_pkg::sample_t     left_sample,
    input  fir_pkg::coef_t       left_coef,
    output fir_pkg::sample_t     sample,
    output fir_pkg::coef_t       coef
);

    fir_pkg::sample_t sample_reg;
    fir_pkg::sample_t sample_next;
    fir_pkg::coef_t   coef_reg;
    fir_pkg::coef_t   coef_next;
    logic             hit;

    assign hit = ctrl.wr_en && (32'(ctrl.wr_idx) == 32'(INDEX));

    always_comb
    begin
        sample_next = sample_reg;
        coef_next   = coef_reg;
        priority if (ctrl.clear)
        begin
            sample_next = '0;
            coef_next   = '0;
        end
        else if (ctrl.shift)
        begin
            sample_next = left_sample;
        end
        else if (ctrl.rotate)
        begin
            // whole ring moves one place, back home after a full lap
            sample_next = left_sample;
            coef_next   = left_coef;
        end
        else if (hit)
        begin
            coef_next = ctrl.wr_value;
        end
        else
        begin
            sample_next = sample_reg;
            coef_next   = coef_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= (INDEX == 0) ? fir_pkg::COEF_ONE : '0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
        end
    end

    assign sample = sample_reg;
    assign coef   = coef_reg;

endmodule

`default_nettype wire

[rtl/fir_mac.sv]
`default_nettype none

module fir_mac #(
    parameter int ACC_W = 37
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  fir_pkg::mac_ctrl_t       ctrl,
    input  fir_pkg::coef_t           coef,
    input  fir_pkg::sample_t         sample,
    output logic signed [ACC_W-1:0]  acc
);

    localparam int PROD_W = 2 * fir_pkg::DATA_W;

    logic signed [PROD_W-1:0] product_reg;
    logic                     pvalid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.start)
        begin
            acc_next = '0;
        end
        else if (pvalid_reg)
        begin
            acc_next = acc_reg + ACC_W'(product_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= ctrl.en;
        end
    end

    always_ff @(posedge clk)
    begin
        product_reg <= coef * sample;
        acc_reg     <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

[rtl/fir_filter.sv]
// channel  dir  payload                                  transfer
// din      in   op, sample_in, tap_index, tap_value      valid & ready
// dout     out  sample_out, clipped                      valid & ready
//
// a sample is shifted in, makes a full turn of the coefficient/history ring past
// the single multiplier (S_RUN), then drains (S_DRAIN) and is rounded (S_DONE)
// coefficient writes, clears and the unused op are taken without leaving S_IDLE
// rst_n is asynchronous; after it tap zero is unity and the history is zero
// din is taken while a finished result still waits on dout; a stalled dout
// only holds the next sample in its rounding step
`default_nettype none

module fir_filter #(
    parameter int TAPS = 32
) (
    input  wire        clk,
    input  wire        rst_n,
    fir_in_if.sink     din,
    fir_out_if.source  dout
);

    localparam int CNT_W = $clog2(TAPS);
    localparam int ACC_W = 2 * fir_pkg::DATA_W + $clog2(TAPS);
    localparam int SCL_W = ACC_W - fir_pkg::FRAC_SHIFT;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    fir_pkg::sample_t    out_sample_reg;
    fir_pkg::sample_t    out_sample_next;
    logic                out_clip_reg;
    logic                out_clip_next;

    logic                accept;
    logic                load;
    fir_pkg::cell_ctrl_t cell_ctrl;
    fir_pkg::mac_ctrl_t  mac_ctrl;
    fir_pkg::sample_t    sample_w [TAPS];
    fir_pkg::coef_t      coef_w   [TAPS];
    fir_pkg::sample_t    ring_in;

    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rounded;
    logic signed [SCL_W-1:0] scaled;
    fir_pkg::sample_t        sat_value;
    logic                    sat_clip;

    assign din.ready = (state_reg == S_IDLE);
    assign accept    = din.valid && din.ready;

    always_comb
    begin
        cell_ctrl.shift    = accept && (din.op == fir_pkg::OP_SAMPLE);
        cell_ctrl.clear    = accept && (din.op == fir_pkg::OP_CLEAR);
        cell_ctrl.wr_en    = accept && (din.op == fir_pkg::OP_WRITE);
        cell_ctrl.rotate   = (state_reg == S_RUN);
        cell_ctrl.wr_idx   = din.tap_index;
        cell_ctrl.wr_value = din.tap_value;
        mac_ctrl.start     = cell_ctrl.shift;
        mac_ctrl.en        = (state_reg == S_RUN);
    end

    // new sample enters at the head, otherwise the tail wraps round
    assign ring_in = cell_ctrl.shift ? din.sample_in : sample_w[TAPS-1];

    for (genvar k = 0; k < TAPS; k++)
    begin : g_cell
        fir_cell #(
            .INDEX (k)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (cell_ctrl),
            .left_sample ((k == 0) ? ring_in : sample_w[(k == 0) ? 0 : k-1]),
            .left_coef   ((k == 0) ? coef_w[TAPS-1] : coef_w[(k == 0) ? 0 : k-1]),
            .sample      (sample_w[k]),
            .coef        (coef_w[k])
        );
    end

    fir_mac #(
        .ACC_W (ACC_W)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .coef   (coef_w[TAPS-1]),
        .sample (sample_w[TAPS-1]),
        .acc    (acc)
    );

    // round half up, floor shift to q1.15, then clamp
    always_comb
    begin
        rounded   = acc + ACC_W'(fir_pkg::ROUND_HALF);
        scaled    = rounded[ACC_W-1:fir_pkg::FRAC_SHIFT];
        priority if (scaled > SCL_W'(fir_pkg::SAMPLE_MAX))
        begin
            sat_value = fir_pkg::SAMPLE_MAX;
            sat_clip  = 1'b1;
        end
        else if (scaled < SCL_W'(fir_pkg::SAMPLE_MIN))
        begin
            sat_value = fir_pkg::SAMPLE_MIN;
            sat_clip  = 1'b1;
        end
        else
        begin
            sat_value = scaled[fir_pkg::DATA_W-1:0];
            sat_clip  = 1'b0;
        end
    end

    assign load = (state_reg == S_DONE) && (!out_valid_reg || dout.ready);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_sample_next = out_sample_reg;
        out_clip_next   = out_clip_reg;
        out_valid_next  = out_valid_reg && !dout.ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cell_ctrl.shift)
                begin
                    state_next = S_RUN;
                    count_next = '0;
                end
            end
            S_RUN:
            begin
                count_next = count_reg + CNT_W'(1);
                if (count_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (load)
                begin
                    out_valid_next  = 1'b1;
                    out_sample_next = sat_value;
                    out_clip_next   = sat_clip;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_sample_reg <= '0;
            out_clip_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_sample_reg <= out_sample_next;
            out_clip_reg   <= out_clip_next;
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.sample_out = out_sample_reg;
    assign dout.clipped    = out_clip_reg;

endmodule

`default_nettype wire

[rtl/fir_checker.sv]
`default_nettype none

module fir_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               in_valid,
    input wire               in_ready,
    input wire [1:0]         in_op,
    input wire               out_valid,
    input wire               out_ready,
    input wire signed [15:0] out_sample,
    input wire               out_clipped
);

    // a result on offer stays until transferred
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before transfer");

    // a sample keeps the input closed while the ring turns
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op == fir_pkg::OP_SAMPLE) |=> !in_ready)
        else $error("input open during sample computation");

    // writes, clears and unused ops leave the input ready on the next cycle
    a_ctrl_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_op != fir_pkg::OP_SAMPLE) |=> in_ready)
        else $error("input closed after a non-sample transfer");

    // a clipped result sits on a rail
    a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_clipped) |->
            (out_sample == fir_pkg::SAMPLE_MAX || out_sample == fir_pkg::SAMPLE_MIN))
        else $error("clipped flag without saturated value");

    // a new result only appears at the end of a sample computation
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared while idle");

endmodule

bind fir_filter fir_checker u_fir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (din.valid),
    .in_ready    (din.ready),
    .in_op       (din.op),
    .out_valid   (dout.valid),
    .out_ready   (dout.ready),
    .out_sample  (dout.sample_out),
    .out_clipped (dout.clipped)
);

`default_nettype wire
